FILE: src/pid_controller_step_assert.svh
// Assertion macros for the PID step block.
// Used by pid_controller_step and pidc_mul; no other dependencies.
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH
`ifndef SYNTHESIS
// Check on an explicit clock and active-low reset.
`define PIDC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on the house clock clk_i and reset rst_ni.
`define PIDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define PIDC_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define PIDC_ASSERT(label, prop, msg)
`endif
`endif

FILE: src/pidc_pkg.sv
// Shared constants, codes and unit interface structs of the PID step block.
// No dependencies; imported by every module of the block.
package pidc_pkg;

  // accumulated integral width, Q(INTEGRAL_WIDTH-16).16
  localparam int INTEGRAL_WIDTH = 48;

  localparam int DATA_W  = 32;   // Q16.16 error, output, gains
  localparam int STEP_W  = 16;   // Q0.16 time step
  localparam int GAIN_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 2;

  // multiply unit: 64-bit magnitude split into two 32-bit halves
  localparam int MAG_W      = 64;
  localparam int MUL_HALF   = MAG_W / 2;
  localparam int ACC_W      = MAG_W + GAIN_W;
  localparam int RND_W      = ACC_W - FRAC_W;
  localparam int CLAMP_LOG2 = 48;                 // term magnitude limit 2^48
  localparam int TERM_W     = CLAMP_LOG2 + 2;
  localparam int SUM_W      = TERM_W + 1;         // three terms

  // divider: |diff| << 16, padded to an even count, two bits a step
  localparam int DIFF_W    = DATA_W + 1;
  localparam int DIV_N     = DIFF_W + FRAC_W + 1;
  localparam int DIV_STEPS = DIV_N / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TERM_W-2:0] TERM_CLAMP = {1'b1, {(TERM_W-2){1'b0}}};
  localparam logic [DATA_W-1:0] DATA_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  // func codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic                     start;
    logic signed [MAG_W-1:0]  a;
    logic signed [GAIN_W-1:0] g;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic                     busy;
    logic signed [TERM_W-1:0] term;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] mag;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DIV_N-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/pidc_mul.sv
// Shared multiply-shift unit: floor(a * g / 2^16), magnitude clamped to 2^48.
// One 32x32 multiplier used twice per operation. Depends on pidc_pkg.
`include "pid_controller_step_assert.svh"

module pidc_mul
  import pidc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    MP_IDLE = 4'b0001,
    MP_LO   = 4'b0010,
    MP_HI   = 4'b0100,
    MP_FIN  = 4'b1000
  } mul_ph_e;

  localparam logic signed [TERM_W-1:0] TERM_LIM = signed'({1'b0, TERM_CLAMP});

  mul_ph_e ph_q, ph_d;
  logic    done_q;

  logic [MAG_W-1:0]         ma_q, ma_in;
  logic [GAIN_W-1:0]        mg_q, mg_in;
  logic                     neg_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [TERM_W-1:0] term_q, term_fin;

  logic [MUL_HALF-1:0]      mul_a;
  logic [2*MUL_HALF-1:0]    prod;
  logic [RND_W-1:0]         m_raw;
  logic [TERM_W-2:0]        m_clip;

  assign ma_in = req_i.a[MAG_W-1]  ? MAG_W'(-req_i.a)  : MAG_W'(req_i.a);
  assign mg_in = req_i.g[GAIN_W-1] ? GAIN_W'(-req_i.g) : GAIN_W'(req_i.g);

  // low half first, then high half
  assign mul_a = (ph_q == MP_HI) ? ma_q[MAG_W-1:MUL_HALF] : ma_q[MUL_HALF-1:0];
  assign prod  = (2*MUL_HALF)'(mul_a) * (2*MUL_HALF)'(mg_q);

  // round toward minus infinity on the signed result, then clamp
  always_comb begin
    m_raw = acc_q[ACC_W-1:FRAC_W] + RND_W'(neg_q & (|acc_q[FRAC_W-1:0]));
    if (m_raw > RND_W'(TERM_CLAMP)) begin
      m_clip = TERM_CLAMP;
    end else begin
      m_clip = m_raw[TERM_W-2:0];
    end
    term_fin = neg_q ? -signed'({1'b0, m_clip}) : signed'({1'b0, m_clip});
  end

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      MP_IDLE: if (req_i.start) ph_d = MP_LO;
      MP_LO:   ph_d = MP_HI;
      MP_HI:   ph_d = MP_FIN;
      MP_FIN:  ph_d = MP_IDLE;
      default: ph_d = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= MP_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == MP_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == MP_IDLE && req_i.start) begin
      ma_q  <= ma_in;
      mg_q  <= mg_in;
      neg_q <= req_i.a[MAG_W-1] ^ req_i.g[GAIN_W-1];
    end
    if (ph_q == MP_LO) begin
      acc_q <= {{(ACC_W-2*MUL_HALF){1'b0}}, prod};
    end
    if (ph_q == MP_HI) begin
      acc_q <= acc_q + {prod, {(ACC_W-2*MUL_HALF){1'b0}}};
    end
    if (ph_q == MP_FIN) begin
      term_q <= term_fin;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (ph_q != MP_IDLE);
  assign rsp_o.term = term_q;

  `PIDC_ASSERT(a_mul_start_idle, req_i.start |-> ph_q == MP_IDLE, "multiply started while busy")
  `PIDC_ASSERT(a_mul_done_fin, done_q |-> $past(ph_q == MP_FIN), "done without final phase")
  `PIDC_ASSERT(a_mul_term_lim, done_q |-> (term_q <= TERM_LIM && term_q >= -TERM_LIM), "term beyond clamp")

endmodule

FILE: src/pidc_div.sv
// Radix-4 restoring divider for the derivative: (|diff| << 16) / step.
// Two quotient bits per cycle; no new start is taken while busy. Depends on pidc_pkg.

module pidc_div
  import pidc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N-1:0]     num_q, quot_q;
  logic [STEP_W-1:0]    rem_q, dv_q;

  logic [STEP_W:0]      r1, r1n, r2, r2n;
  logic                 ge1, ge2;
  logic                 last_step;

  always_comb begin
    r1  = {rem_q, num_q[DIV_N-1]};
    ge1 = (r1 >= {1'b0, dv_q});
    r1n = ge1 ? (r1 - {1'b0, dv_q}) : r1;
    r2  = {r1n[STEP_W-1:0], num_q[DIV_N-2]};
    ge2 = (r2 >= {1'b0, dv_q});
    r2n = ge2 ? (r2 - {1'b0, dv_q}) : r2;
  end

  assign last_step = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      num_q <= {1'b0, req_i.mag, {FRAC_W{1'b0}}};
      rem_q <= '0;
      dv_q  <= req_i.divisor;
    end else if (busy_q) begin
      num_q  <= {num_q[DIV_N-3:0], 2'b00};
      rem_q  <= r2n[STEP_W-1:0];
      quot_q <= {quot_q[DIV_N-3:0], ge1, ge2};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: src/pid_controller_step.sv
// Top level of the fixed-point discrete PID step: sequencer, state, output stage.
// Depends on pidc_pkg, pidc_mul, pidc_div and pid_controller_step_assert.svh.
`include "pid_controller_step_assert.svh"

// Discrete PID step, Q16.16. Each input word is an update (tuser = 0) or a
// clear (tuser = 1). For an update with a nonzero step the derivative
// divider forms two quotient bits per cycle while the shared 32x32
// multiplier forms the integral increment e*dt alongside it, then the same
// multiplier forms the p, i and d terms one after another, and the S_DONE
// state saturates the sum into the output register. A clear or a zero step
// goes to S_DONE and produces drive 0; a zero step leaves the state untouched.
// s_axis_tready is high only while the sequencer is idle; the output
// register lets the next word be accepted while a result is still waiting.
// Gains are written over the cfg port (index 0 p, 1 i, 2 d; index 3 is
// dropped); the user must write them only while the block is idle, which
// the block itself does not enforce. Each term is clamped to +-2^48, the
// integral saturates at INTEGRAL_WIDTH bits, the derivative at 32 bits, and
// output tuser flags an integral or derivative clip or output saturation.

module pid_controller_step
  import pidc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input word
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,   // [31:0] error_in, [47:32] time_step
  input  logic                 s_axis_tuser,   // [0] func
  // result word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [31:0] drive_out
  output logic                 m_axis_tuser    // [0] saturated
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MULP = 6'b000100,
    S_MULI = 6'b001000,
    S_MULD = 6'b010000,
    S_DONE = 6'b100000
  } pidc_state_e;

  localparam int IW = INTEGRAL_WIDTH;

  pidc_state_e state_q, state_d;

  // controller state and gains
  logic signed [IW-1:0]     integral_q, integral_d;
  logic signed [DATA_W-1:0] last_q, last_d;
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

  // per-item working registers
  logic signed [DATA_W-1:0] e_q, e_d;
  logic                     dneg_q, dneg_d;
  logic signed [DATA_W-1:0] deriv_q, deriv_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     sat_q, sat_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_data_q, out_data_d;
  logic                     out_sat_q, out_sat_d;

  // input word fields
  logic                     in_func;
  logic signed [DATA_W-1:0] in_error;
  logic [STEP_W-1:0]        in_step;
  logic                     s_acc;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // integral update
  logic signed [DATA_W-1:0] inc;
  logic signed [IW:0]       isum;
  logic signed [IW-1:0]     isat;
  logic                     iclip;

  // derivative clamp
  logic signed [DATA_W-1:0] dsat;
  logic                     dclip;

  // output saturation
  logic [SUM_W-DATA_W:0]    sum_top;
  logic                     oclip;
  logic [DATA_W-1:0]        drive;

  assign in_func  = s_axis_tuser;
  assign in_error = s_axis_tdata[DATA_W-1:0];
  assign in_step  = s_axis_tdata[DATA_W+STEP_W-1:DATA_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign diff     = DIFF_W'(in_error) - DIFF_W'(last_q);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // I = sat(I + e*dt/2^16); the increment always fits in 32 bits
  always_comb begin
    inc   = mul_rsp.term[DATA_W-1:0];
    isum  = (IW+1)'(integral_q) + (IW+1)'(inc);
    iclip = (isum[IW] != isum[IW-1]);
    if (iclip) begin
      isat = isum[IW] ? signed'({1'b1, {(IW-1){1'b0}}}) : signed'({1'b0, {(IW-1){1'b1}}});
    end else begin
      isat = isum[IW-1:0];
    end
  end

  // D = +-quotient, clamped to signed 32 bits
  always_comb begin
    if (dneg_q) begin
      dclip = (div_rsp.quot > DIV_N'(DATA_MIN));
      dsat  = dclip ? signed'(DATA_MIN) : -signed'(div_rsp.quot[DATA_W-1:0]);
    end else begin
      dclip = (div_rsp.quot > DIV_N'(DATA_MAX));
      dsat  = dclip ? signed'(DATA_MAX) : signed'(div_rsp.quot[DATA_W-1:0]);
    end
  end

  // sum fits in 32 bits when all bits above bit 30 agree
  always_comb begin
    sum_top = sum_q[SUM_W-1:DATA_W-1];
    oclip   = !((&sum_top) || !(|sum_top));
    if (oclip) begin
      drive = sum_q[SUM_W-1] ? DATA_MIN : DATA_MAX;
    end else begin
      drive = sum_q[DATA_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    integral_d  = integral_q;
    last_d      = last_q;
    e_d         = e_q;
    dneg_d      = dneg_q;
    deriv_d     = deriv_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_sat_d   = out_sat_q;

    mul_req         = '0;
    div_req.start   = 1'b0;
    div_req.mag     = diff_mag;
    div_req.divisor = in_step;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        mul_req.a = MAG_W'(in_error);
        mul_req.g = GAIN_W'(in_step);
        if (s_acc) begin
          e_d    = in_error;
          dneg_d = diff[DIFF_W-1];
          sum_d  = '0;
          sat_d  = 1'b0;
          if (in_func == FUNC_CLEAR) begin
            integral_d = '0;
            last_d     = '0;
            state_d    = S_DONE;
          end else if (in_step == '0) begin
            state_d = S_DONE;
          end else begin
            last_d        = in_error;
            mul_req.start = 1'b1;
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        // increment finishes long before the quotient
        if (mul_rsp.done) begin
          integral_d = isat;
          if (iclip) sat_d = 1'b1;
        end
        if (div_rsp.done) begin
          deriv_d = dsat;
          if (dclip) sat_d = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = MAG_W'(e_q);
          mul_req.g     = gain_p_q;
          state_d       = S_MULP;
        end
      end
      S_MULP: begin
        if (mul_rsp.done) begin
          sum_d         = SUM_W'(mul_rsp.term);
          mul_req.start = 1'b1;
          mul_req.a     = MAG_W'(integral_q);
          mul_req.g     = gain_i_q;
          state_d       = S_MULI;
        end
      end
      S_MULI: begin
        if (mul_rsp.done) begin
          sum_d         = sum_q + SUM_W'(mul_rsp.term);
          mul_req.start = 1'b1;
          mul_req.a     = MAG_W'(deriv_q);
          mul_req.g     = gain_d_q;
          state_d       = S_MULD;
        end
      end
      S_MULD: begin
        if (mul_rsp.done) begin
          sum_d   = sum_q + SUM_W'(mul_rsp.term);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = drive;
          out_sat_d   = sat_q | oclip;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      integral_q  <= '0;
      last_q      <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      integral_q  <= integral_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GAIN_P: gain_p_q <= cfg_data_i;
          REG_GAIN_I: gain_i_q <= cfg_data_i;
          REG_GAIN_D: gain_d_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q        <= e_d;
    dneg_q     <= dneg_d;
    deriv_q    <= deriv_d;
    sum_q      <= sum_d;
    sat_q      <= sat_d;
    out_data_q <= out_data_d;
    out_sat_q  <= out_sat_d;
  end

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  `PIDC_ASSERT(a_clear_zeroes, (s_acc && in_func == FUNC_CLEAR) |=> (integral_q == '0 && last_q == '0), "clear left state")
  `PIDC_ASSERT(a_zero_step_hold, (s_acc && in_func == FUNC_UPDATE && in_step == '0) |=> $stable(integral_q), "zero step changed integral")
  `PIDC_ASSERT(a_inc_before_div, (state_q == S_DIV && div_rsp.done) |-> !mul_rsp.busy, "quotient before increment")
  `PIDC_ASSERT(a_idle_units, s_axis_tready |-> (!mul_rsp.busy && !div_rsp.busy), "unit busy while idle")

endmodule

FILE: tb/pid_controller_step_tb.sv
// Self-checking testbench for the fixed-point PID step block.
// It needs pidc_pkg and the pid_controller_step RTL. It drives stream words and
// gain writes, predicts every result in-line, and checks each result word.
module testbench;
  import pidc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // index 3 is not a gain: the block drops the write
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int LATENCY_TAIL = 64;    // tail wait, longer than one full update
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 144;
  localparam int MAX_REPORTS  = 10;

  localparam logic [63:0]        TERM_LIMIT = 64'd1 << CLAMP_LOG2;
  localparam logic signed [63:0] INTEG_MAX  = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] INTEG_MIN  = -INTEG_MAX - 64'sd1;
  localparam logic signed [63:0] OUT_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] OUT_MIN    = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [31:0] drive;
    logic        sat;
  } pid_result_t;

  typedef enum logic {ROW_ITEM, ROW_GAINS} row_kind_e;

  typedef enum int {GAINS_MILD, GAINS_WIDE, GAINS_EDGE} gain_style_e;

  // One directed step. Gain rows load the gain set named by gset.
  // typed = 1: expectation is read straight off the row, else the predictor decides.
  typedef struct packed {
    row_kind_e   kind;
    logic        func;
    logic [31:0] err;
    logic [15:0] dt;
    logic        typed;
    logic [31:0] drive;
    logic        sat;
    logic [1:0]  gset;
  } plan_row_t;

  // gain sets for the directed part: {p, i, d}
  localparam logic [31:0] DIR_GAINS [3][3] = '{
    '{32'h0001_0000, 32'h0000_8000, 32'h0000_0100},   // 1.0, 0.5, 1/256
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},   // extremes
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}    // extremes, flipped
  };

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // all gains zero after reset: drive is 0, only the clip flag can show
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0000_0000, 16'h8000, 1'b1, 32'h0, 1'b0, 2'd0},
    // full-scale error over the smallest step: derivative clips high
    '{ROW_ITEM,  FUNC_UPDATE, 32'h7FFF_FFFF, 16'h0001, 1'b1, 32'h0, 1'b1, 2'd0},
    // swing to the most negative error: derivative clips low
    '{ROW_ITEM,  FUNC_UPDATE, 32'h8000_0000, 16'h0001, 1'b1, 32'h0, 1'b1, 2'd0},
    // zero step: drive 0, state untouched
    '{ROW_ITEM,  FUNC_UPDATE, 32'h1234_5678, 16'h0000, 1'b1, 32'h0, 1'b0, 2'd0},
    // clear with junk in the data fields
    '{ROW_ITEM,  FUNC_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0000_0000, 16'hFFFF, 1'b1, 32'h0, 1'b0, 2'd0},
    '{ROW_GAINS, FUNC_UPDATE, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0001_0000, 16'h8000, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'hFFFF_0000, 16'hFFFF, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h1234_5678, 16'h0000, 1'b1, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0002_0000, 16'h0001, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_CLEAR,  32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0000_0001, 16'h0001, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_GAINS, FUNC_UPDATE, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 2'd1},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h8000_0000, 16'hFFFF, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'hFFFF_FFFF, 16'h0001, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_CLEAR,  32'h5555_AAAA, 16'h1234, 1'b1, 32'h0, 1'b0, 2'd0},
    '{ROW_GAINS, FUNC_UPDATE, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 2'd2},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h8000_0000, 16'h8000, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0000_0000, 16'h0001, 1'b0, 32'h0, 1'b0, 2'd0},
    '{ROW_ITEM,  FUNC_UPDATE, 32'h0000_FFFF, 16'h0000, 1'b1, 32'h0, 1'b0, 2'd0}
  };

  // ---------------------------------------------------------------- DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata;   // [31:0] error_in, [47:32] time_step
  logic                 s_axis_tuser;   // [0] func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;   // [31:0] drive_out
  logic                 m_axis_tuser;   // [0] saturated

  pid_controller_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------- predictor state
  logic signed [63:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [63:0] integ_q;      // running integral, Q.16
  logic signed [63:0] prev_err_q;   // error of the last real update

  pid_result_t expected_drive_q [$];

  // shared between the stimulus and the receiver
  bit steady;     // no idling on either side
  bit hold_req;   // receiver: hold tready low for HOLD_CYCLES

  int fail_count;
  int cycle_count;
  int n_updates, n_zero_steps, n_clears, n_gain_loads;
  int n_results, n_sat_seen;

  // floor(x * g / 2^16), magnitude clamped to 2^48. Done on magnitudes and
  // split into 32-bit halves so nothing overflows 64 bits.
  function automatic logic signed [63:0] gain_term(input logic signed [63:0] x,
                                                   input logic signed [63:0] g);
    logic        neg;
    logic [63:0] mx, mg, hi, lo, m;
    neg = x[63] ^ g[63];
    mx  = x[63] ? (~x + 64'd1) : x;
    mg  = g[63] ? (~g + 64'd1) : g;
    hi  = (mx >> 32) * mg;
    lo  = (mx & 64'h0000_0000_FFFF_FFFF) * mg;
    if (hi >= (64'd1 << 32)) begin
      m = TERM_LIMIT;
    end else begin
      m = (hi << 16) + (lo >> 16);
      // negative product rounds toward minus infinity
      if (neg && lo[15:0] != 16'd0) m = m + 64'd1;
      if (m > TERM_LIMIT) m = TERM_LIMIT;
    end
    return neg ? $signed(~m + 64'd1) : $signed(m);
  endfunction

  // Expected result of one accepted word; advances the integral and last error.
  function automatic pid_result_t predict_drive(input logic func,
                                                input logic signed [31:0] err,
                                                input logic [15:0] dt);
    pid_result_t        res;
    logic signed [63:0] e64, inc, acc, diff, deriv, total;
    logic [63:0]        mag, quo;
    res = '0;
    if (func == FUNC_CLEAR) begin
      integ_q    = '0;
      prev_err_q = '0;
      return res;
    end
    if (dt == 16'd0) return res;   // zero step: nothing moves

    e64 = err;
    inc = gain_term(e64, $signed({48'd0, dt}));
    acc = integ_q + inc;
    if (acc > INTEG_MAX) begin
      acc     = INTEG_MAX;
      res.sat = 1'b1;
    end else if (acc < INTEG_MIN) begin
      acc     = INTEG_MIN;
      res.sat = 1'b1;
    end
    integ_q = acc;

    // derivative: (diff << 16) / dt, truncated toward zero, clipped to 32 bits
    diff = e64 - prev_err_q;
    mag  = diff[63] ? (~diff + 64'd1) : diff;
    quo  = (mag << 16) / {48'd0, dt};
    if (diff[63]) begin
      if (quo > (64'd1 << 31)) begin
        quo     = 64'd1 << 31;
        res.sat = 1'b1;
      end
      deriv = $signed(~quo + 64'd1);
    end else begin
      if (quo > 64'h0000_0000_7FFF_FFFF) begin
        quo     = 64'h0000_0000_7FFF_FFFF;
        res.sat = 1'b1;
      end
      deriv = $signed(quo);
    end
    prev_err_q = e64;

    total = gain_term(e64, gain_p_q) + gain_term(integ_q, gain_i_q)
          + gain_term(deriv, gain_d_q);
    if (total > OUT_MAX) begin
      total   = OUT_MAX;
      res.sat = 1'b1;
    end else if (total < OUT_MIN) begin
      total   = OUT_MIN;
      res.sat = 1'b1;
    end
    res.drive = total[31:0];
    return res;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_gain(input gain_style_e style);
    case (style)
      GAINS_WIDE: return $urandom();
      GAINS_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      // within +-4.0
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  // ------------------------------------------------------------- drivers
  // Leaves cfg_valid_i high so back-to-back writes need no extra edge.
  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      REG_GAIN_P: gain_p_q = $signed(val);
      REG_GAIN_I: gain_i_q = $signed(val);
      REG_GAIN_D: gain_d_q = $signed(val);
      default: ;   // dropped by the block
    endcase
  endtask

  task automatic load_gains(input logic [31:0] p, input logic [31:0] ig,
                            input logic [31:0] d, input logic poke_unused);
    cfg_word(REG_GAIN_P, p);
    cfg_word(REG_GAIN_I, ig);
    cfg_word(REG_GAIN_D, d);
    if (poke_unused) cfg_word(REG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
    n_gain_loads++;
  endtask

  // append one expectation at the tail of the scoreboard
  task automatic book_result(input pid_result_t res);
    expected_drive_q = {expected_drive_q, res};
  endtask

  // Offer one word and book its expectation at the accepting edge.
  // tvalid stays high; the caller drops it if a gap follows.
  task automatic offer_word(input logic func, input logic [31:0] err, input logic [15:0] dt,
                            input logic typed, input pid_result_t typed_res);
    pid_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, err};
    s_axis_tuser  <= func;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    predicted = predict_drive(func, err, dt);
    book_result(typed ? typed_res : predicted);
    if (func == FUNC_CLEAR) n_clears++;
    else if (dt == 16'd0) n_zero_steps++;
    else n_updates++;
  endtask

  task automatic sender_gap();
    int n;
    n = steady ? 0 : idle_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every booked result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------ receiver
  initial begin
    int n;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        // long hold-off: block fills its output register and stalls input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = steady ? 0 : idle_len();
        if (n == 0) begin
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  // ------------------------------------------------------------- checker
  always @(posedge clk_i) begin : result_check
    pid_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser) n_sat_seen++;
      if (expected_drive_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: drive %h sat %b",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = expected_drive_q.pop_front();
        if (m_axis_tdata !== want.drive || m_axis_tuser !== want.sat) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] result mismatch: drive exp %h got %h, sat exp %b got %b",
                     $realtime, want.drive, m_axis_tdata, want.sat, m_axis_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_drive_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------ stimulus
  initial begin
    plan_row_t   row;
    pid_result_t want;
    gain_style_e style;
    logic        func;
    logic [31:0] err, last_err;
    logic [15:0] dt;
    int          pick;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GAIN_P;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_UPDATE;
    gain_p_q      = '0;
    gain_i_q      = '0;
    gain_d_q      = '0;
    integ_q       = '0;
    prev_err_q    = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    last_err      = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: reset gains, extremes, clears and zero steps
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      if (row.kind == ROW_GAINS) begin
        drain();
        load_gains(DIR_GAINS[row.gset][0], DIR_GAINS[row.gset][1],
                   DIR_GAINS[row.gset][2], row.gset == 2'd1);
      end else begin
        want.drive = row.drive;
        want.sat   = row.sat;
        offer_word(row.func, row.err, row.dt, row.typed, want);
        sender_gap();
      end
    end

    // random part: each phase reloads the gains while idle, then streams
    // mostly slowly drifting errors like a real loop, with noise mixed in
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      style = (ph == 4) ? GAINS_EDGE : (ph % 3 == 2) ? GAINS_WIDE : GAINS_MILD;
      load_gains(pick_gain(style), pick_gain(style), pick_gain(style), ph % 2 == 1);
      steady   = (ph == 2 || ph == 6);
      hold_req = (ph == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        func = ($urandom_range(0, 29) == 0) ? FUNC_CLEAR : FUNC_UPDATE;

        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          case ($urandom_range(0, 4))
            0:       err = 32'h7FFF_FFFF;
            1:       err = 32'h8000_0000;
            2:       err = 32'h0000_0000;
            3:       err = 32'h0000_0001;
            default: err = 32'hFFFF_FFFF;
          endcase
        end else if (pick < 30) begin
          err = $urandom();
        end else if (pick < 65) begin
          err = last_err + int'($urandom_range(0, 8191)) - 4096;
        end else begin
          err = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        end
        last_err = err;

        pick = $urandom_range(0, 99);
        if (pick < 6) dt = 16'd0;
        else if (pick < 16) dt = 16'($urandom_range(1, 16));
        else if (pick < 22) dt = 16'hFFFF;
        else dt = 16'($urandom_range(1, 65535));

        want = '0;
        offer_word(func, err, dt, 1'b0, want);
        sender_gap();
        // sender pause: let the pipeline run completely dry once
        if (ph == 3 && n == PHASE_WORDS / 2) drain();
      end
    end

    drain();
    repeat (LATENCY_TAIL) @(posedge clk_i);
    if (expected_drive_q.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_drive_q.size());
    end

    $display("Sent %0d updates, %0d zero steps and %0d clears under %0d gain loads.",
             n_updates, n_zero_steps, n_clears, n_gain_loads);
    $display("Checked %0d result words, %0d of them flagged as clipped; %0d failures.",
             n_results, n_sat_seen, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
